[src/slipm_pkg.sv]
// Shared types and constants for the sorted list insert / pop-max block.
// Used by slipm_ram and sorted_list_insert_pop_max; depends on nothing.
`timescale 1ns / 1ps

package slipm_pkg;

	localparam int ELEM_W        = 32;
	localparam int ENTRY_COUNT_W = 7;
	localparam int STATUS_W      = 2;

	// operation selector carried on the input tuser
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	// status codes of a result word
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef logic signed [ELEM_W-1:0] elem_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_EMIT_RD,
		S_EMIT_OUT,
		S_RESP
	} state_t;

endpackage

[src/sorted_list_insert_pop_max.sv]
// Sorted list with ordered insert and pop-max, streamed list dump after each word.
// Top level; uses slipm_pkg and slipm_ram.
`timescale 1ns / 1ps

// Keeps up to DEPTH signed 32-bit values in ascending order in a one-read,
// one-write memory. An insert (tuser 0) walks down from the top of the list,
// moving each larger entry up one place with a single shared signed compare,
// and drops the value in behind the last entry that is less than or equal to
// it. A delete (tuser 1) drops the largest value. After every word the whole
// list is streamed out, smallest first, one word per cycle while the output
// is not stalled, with tlast on the final word; an empty list, a delete on an
// empty list and an insert into a full list each give one word with
// has_element low and the matching status. Insert and delete times are set
// by the single memory port and the one compare unit. The input is ready only
// while the sequencer is idle; the output register lets the next word be
// taken while the last result still waits.
module sorted_list_insert_pop_max #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input: tdata [31:0] value
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	// input: tuser [0] operation
	input  logic [0:0]  s_tuser,
	// result: tdata [31:0] element, [38:32] entry_count, [39] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,
	// result: tuser [0] has_element, [2:1] status
	output logic [2:0]  m_tuser,
	output logic        m_tlast
);
	import slipm_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	state_t state_q, state_d;

	logic [CW-1:0]       count_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       eidx_q;
	elem_t               val_q;
	logic [STATUS_W-1:0] status_q;

	// memory port signals
	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	elem_t         wdata, rdata;

	// output register
	logic                     m_valid_q;
	elem_t                    out_elem_q;
	logic                     out_has_q;
	logic [ENTRY_COUNT_W-1:0] out_count_q;
	logic [STATUS_W-1:0]      out_status_q;
	logic                     out_last_q;

	// output load request
	logic                out_load;
	elem_t               out_elem;
	logic                out_has;
	logic [STATUS_W-1:0] out_status;
	logic                out_last;

	// shared helpers
	logic          accept;
	logic          slot_free;
	logic          rd_gt;
	logic          emit_last;
	logic [CW-1:0] idx_m1, idx_m2, eidx_p1, count_m1;

	slipm_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// helpers: one signed compare unit, index arithmetic
	always_comb begin
		accept    = s_tvalid && s_tready;
		slot_free = !m_valid_q || m_tready;
		rd_gt     = rdata > val_q;
		idx_m1    = idx_q - CW'(1);
		idx_m2    = idx_q - CW'(2);
		eidx_p1   = eidx_q + CW'(1);
		count_m1  = count_q - CW'(1);
		emit_last = (eidx_p1 == count_q);
	end

	assign s_tready = (state_q == S_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (s_tuser[0] == OP_DELETE) begin
						if (count_q == '0 || count_m1 == '0) begin
							state_d = S_RESP;
						end else begin
							state_d = S_EMIT_RD;
						end
					end else if (count_q == CW'(DEPTH)) begin
						state_d = S_RESP;
					end else begin
						state_d = S_INS_RD;
					end
				end
			end
			S_INS_RD: begin
				if (idx_q == '0) begin
					state_d = S_EMIT_RD;
				end else begin
					state_d = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				if (!rd_gt) begin
					state_d = S_EMIT_RD;
				end else if (idx_m1 == '0) begin
					state_d = S_INS_RD;
				end
			end
			S_EMIT_RD: begin
				state_d = S_EMIT_OUT;
			end
			S_EMIT_OUT: begin
				if (slot_free && emit_last) begin
					state_d = S_IDLE;
				end
			end
			S_RESP: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// memory port and output load control
	always_comb begin
		we         = 1'b0;
		waddr      = idx_q[AW-1:0];
		wdata      = val_q;
		re         = 1'b0;
		raddr      = idx_m1[AW-1:0];
		out_load   = 1'b0;
		out_elem   = '0;
		out_has    = 1'b0;
		out_status = ST_OK;
		out_last   = 1'b1;
		case (state_q)
			S_INS_RD: begin
				if (idx_q == '0) begin
					we = 1'b1;
				end else begin
					re = 1'b1;
				end
			end
			S_INS_CMP: begin
				// move the larger entry up, or place the new value
				we = 1'b1;
				if (rd_gt) begin
					wdata = rdata;
					if (idx_m1 != '0) begin
						re    = 1'b1;
						raddr = idx_m2[AW-1:0];
					end
				end
			end
			S_EMIT_RD: begin
				re    = 1'b1;
				raddr = eidx_q[AW-1:0];
			end
			S_EMIT_OUT: begin
				if (slot_free) begin
					out_load = 1'b1;
					out_elem = rdata;
					out_has  = 1'b1;
					out_last = emit_last;
					if (!emit_last) begin
						re    = 1'b1;
						raddr = eidx_p1[AW-1:0];
					end
				end
			end
			S_RESP: begin
				if (slot_free) begin
					out_load   = 1'b1;
					out_status = status_q;
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// list count and working indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			idx_q    <= '0;
			eidx_q   <= '0;
			status_q <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					eidx_q <= '0;
					if (accept) begin
						if (s_tuser[0] == OP_DELETE) begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
							end else begin
								status_q <= ST_OK;
								count_q  <= count_m1;
							end
						end else if (count_q == CW'(DEPTH)) begin
							status_q <= ST_FULL;
						end else begin
							status_q <= ST_OK;
							idx_q    <= count_q;
							count_q  <= count_q + CW'(1);
						end
					end
				end
				S_INS_CMP: begin
					if (rd_gt) begin
						idx_q <= idx_m1;
					end
				end
				S_EMIT_OUT: begin
					if (slot_free && !emit_last) begin
						eidx_q <= eidx_p1;
					end
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	// value of the word being inserted
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= elem_t'(s_tdata);
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_elem_q   <= out_elem;
			out_has_q    <= out_has;
			out_count_q  <= ENTRY_COUNT_W'(count_q);
			out_status_q <= out_status;
			out_last_q   <= out_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, out_count_q, out_elem_q};
	assign m_tuser  = {out_status_q, out_has_q};
	assign m_tlast  = out_last_q;

endmodule

[src/slipm_ram.sv]
// Single write port, single read port storage for the sorted list.
// Read data is registered and holds while no read is issued. Uses slipm_pkg.
`timescale 1ns / 1ps

module slipm_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [AW-1:0]          waddr,
	input  slipm_pkg::elem_t       wdata,
	input  logic                   re,
	input  logic [AW-1:0]          raddr,
	output slipm_pkg::elem_t       rdata
);
	import slipm_pkg::*;

	elem_t mem_q [DEPTH];
	elem_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
